// ----- rtl/srg_pkg.sv -----
// Shared types and constants of the stereogram row generator.
// Holds field widths, register codes, the controller command set and the
// status bundle that the datapath returns. No dependencies.
package srg_pkg;

    localparam int DEPTH_W = 8;
    localparam int RGB_W   = 24;
    localparam int COL_W   = 10;
    localparam int REG_W   = 10;
    localparam int ZT_W    = 9;
    localparam int MUQ_W   = 17;
    localparam int DEN_W   = 27;
    localparam int DIV_W   = 28;

    // Probe depth saturates at the number of depth levels (256).
    localparam logic [ZT_W-1:0]  ZT_MAX    = 9'd256;
    localparam logic [REG_W-1:0] EYE_RESET = 10'd248;
    localparam logic [REG_W-1:0] MU_RESET  = 10'd333;

    typedef enum logic {
        REG_EYE_SEP = 1'b0,
        REG_MU      = 1'b1
    } t_reg_idx;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [4:0] {
        C_NOP,
        C_LOAD,
        C_READ,
        C_OUT,
        C_MUQ_SET,
        C_DEN,
        C_LINIT,
        C_COL_RD,
        C_COL_Z,
        C_S_GO,
        C_S_SET,
        C_CHK,
        C_A_SET,
        C_PROBE,
        C_PR_L,
        C_PR_R,
        C_PR_END,
        C_LK_RD,
        C_LK_STEP,
        C_NEXT,
        C_FILL,
        C_FL_L,
        C_FL_C,
        C_DONE
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic read_ok;
        logic out_free;
        logic x_end;
        logic skip_col;
        logic den_zero;
        logic t_le_x;
        logic xpt_in;
        logic mem_lt_zt;
        logic vis;
        logic zt_sat;
        logic lk_cont;
        logic x_zero;
        logic fl_same;
    } t_stat;

endpackage

// ----- rtl/srg_if.sv -----
// Handshake channels of the stereogram row generator: the item input
// channel and the pixel output channel. Depends on srg_pkg for widths.
interface srg_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [srg_pkg::DEPTH_W-1:0]  depth;
    logic [srg_pkg::RGB_W-1:0]    texture_rgb;
    logic                         last_column;

    modport source(output valid, op, depth, texture_rgb, last_column, input ready);
    modport sink(input valid, op, depth, texture_rgb, last_column, output ready);
endinterface

interface srg_out_if;
    logic                         valid;
    logic                         ready;
    logic [srg_pkg::RGB_W-1:0]    pixel_rgb;
    logic [srg_pkg::COL_W-1:0]    column;
    logic                         last_pixel;

    modport source(output valid, pixel_rgb, column, last_pixel, input ready);
    modport sink(input valid, pixel_rgb, column, last_pixel, output ready);
endinterface

// ----- rtl/srg_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module srg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/srg_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Used for the separation and probe step divisions of the row build. No dependencies.
module srg_div #(
    parameter int W = 28
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);

    localparam int CNTW = $clog2(W + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [W-1:0]    r_quo;
    logic [W-1:0]    r_rem;
    logic [W-1:0]    r_den;
    logic [W:0]      trial;
    logic            ge;

    assign trial = {r_rem, r_quo[W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNTW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? W'(trial - {1'b0, r_den}) : W'(trial);
            r_quo <= {r_quo[W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/srg_ctrl.sv -----
// Controller of the stereogram row generator: sequences loads, reads and
// the row build (link pass, probe loop, link walk, colour fill).
// Depends on srg_pkg for the command and status types.
module srg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_op,
    input  logic           i_last,
    input  srg_pkg::t_stat i_stat,
    output logic           o_ready,
    output srg_pkg::t_cmd  o_cmd
);
    import srg_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_MUQ, S_DEN, S_LINIT, S_COL, S_COL_Z, S_S, S_S_W,
        S_CHK, S_A_W, S_PROBE, S_PR_L, S_PR_R, S_PR_END, S_LINK, S_LK, S_NEXT,
        S_FILL, S_FL_L, S_FL_C
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = C_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_op == OP_LOAD) begin
                        o_cmd = C_LOAD;
                        if (i_last) n_state = S_MUQ;
                    end else begin
                        o_cmd = C_READ;
                        if (i_stat.read_ok) n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (i_stat.out_free) begin
                    o_cmd   = C_OUT;
                    n_state = S_IDLE;
                end
            end
            S_MUQ: begin
                o_cmd   = C_MUQ_SET;
                n_state = S_DEN;
            end
            S_DEN: begin
                o_cmd   = C_DEN;
                n_state = S_LINIT;
            end
            S_LINIT: begin
                o_cmd = C_LINIT;
                if (i_stat.x_end) n_state = S_COL;
            end
            S_COL: begin
                if (i_stat.x_end) begin
                    n_state = S_FILL;
                end else begin
                    o_cmd   = C_COL_RD;
                    n_state = S_COL_Z;
                end
            end
            S_COL_Z: begin
                o_cmd   = C_COL_Z;
                n_state = S_S;
            end
            S_S: begin
                o_cmd   = C_S_GO;
                n_state = S_S_W;
            end
            S_S_W: begin
                if (i_stat.div_done) begin
                    o_cmd   = C_S_SET;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd = C_CHK;
                if (i_stat.skip_col) n_state = S_NEXT;
                else if (i_stat.den_zero) n_state = S_PROBE;
                else n_state = S_A_W;
            end
            S_A_W: begin
                if (i_stat.div_done) begin
                    o_cmd   = C_A_SET;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                o_cmd = C_PROBE;
                if (i_stat.t_le_x) n_state = S_PR_L;
                else if (i_stat.xpt_in) n_state = S_PR_R;
                else n_state = S_PR_END;
            end
            S_PR_L: begin
                o_cmd = C_PR_L;
                if (i_stat.mem_lt_zt && i_stat.xpt_in) n_state = S_PR_R;
                else n_state = S_PR_END;
            end
            S_PR_R: begin
                o_cmd   = C_PR_R;
                n_state = S_PR_END;
            end
            S_PR_END: begin
                o_cmd = C_PR_END;
                if (!i_stat.vis) n_state = S_NEXT;
                else if (!i_stat.zt_sat) n_state = S_PROBE;
                else n_state = S_LINK;
            end
            S_LINK: begin
                o_cmd   = C_LK_RD;
                n_state = S_LK;
            end
            S_LK: begin
                o_cmd = C_LK_STEP;
                if (!i_stat.lk_cont) n_state = S_NEXT;
            end
            S_NEXT: begin
                o_cmd   = C_NEXT;
                n_state = S_COL;
            end
            S_FILL: begin
                if (i_stat.x_zero) begin
                    o_cmd   = C_DONE;
                    n_state = S_IDLE;
                end else begin
                    o_cmd   = C_FILL;
                    n_state = S_FL_L;
                end
            end
            S_FL_L: begin
                o_cmd = C_FL_L;
                if (i_stat.fl_same) n_state = S_FILL;
                else n_state = S_FL_C;
            end
            S_FL_C: begin
                o_cmd   = C_FL_C;
                n_state = S_FILL;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

// ----- rtl/srg_dp.sv -----
// Datapath of the stereogram row generator: row memories, fixed-point
// arithmetic, probe and link registers, output register.
// Depends on srg_pkg, srg_ram and srg_div.
module srg_dp #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  srg_pkg::t_reg_idx            i_cfg_idx,
    input  logic [srg_pkg::REG_W-1:0]    i_cfg_data,
    input  srg_pkg::t_cmd                i_cmd,
    output srg_pkg::t_stat               o_stat,
    input  logic [srg_pkg::DEPTH_W-1:0]  i_depth,
    input  logic [srg_pkg::RGB_W-1:0]    i_texture_rgb,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [srg_pkg::RGB_W-1:0]    o_pixel_rgb,
    output logic [srg_pkg::COL_W-1:0]    o_column,
    output logic                         o_last_pixel
);
    import srg_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int NW = CW + 1;
    localparam int AW = (NW > 11) ? NW + 1 : 12;
    localparam logic [NW-1:0] MAXW = NW'(MAX_WIDTH);

    // Control state.
    logic [REG_W-1:0] r_eye, r_mu;
    logic [NW-1:0]    r_load_cnt, r_read_cnt;
    logic             r_row_ready;
    logic             r_out_valid;

    // Work registers.
    logic [MUQ_W-1:0] r_mu_q;
    logic [DEN_W-1:0] r_den;
    logic [NW-1:0]    r_x;
    logic [DEPTH_W-1:0] r_zo;
    logic [MUQ_W-1:0] r_mz;
    logic [REG_W-1:0] r_half;
    logic [CW-1:0]    r_left, r_right;
    logic [AW-1:0]    r_t;
    logic [ZT_W-1:0]  r_qa, r_qstep, r_zt;
    logic [DIV_W-1:0] r_ra, r_rstep;
    logic             r_vis;
    logic [RGB_W-1:0] r_pix_out;
    logic [COL_W-1:0] r_col_out;
    logic             r_last_out;

    // Memory ports.
    logic               dep_we, dep_re, pix_we, pix_re, lnk_we, lnk_re;
    logic [CW-1:0]      dep_raddr, pix_waddr, pix_raddr, lnk_waddr, lnk_wdata, lnk_raddr;
    logic [DEPTH_W-1:0] dep_q;
    logic [RGB_W-1:0]   pix_wdata, pix_q;
    logic [CW-1:0]      lnk_q;

    // Divider ports.
    logic             div_start, div_done;
    logic [DIV_W-1:0] div_num, div_den, div_quo, div_rem;

    // Combinational helpers.
    logic [NW-1:0]    load_idx;
    logic             load_ok, read_ok, x_end, x_zero;
    logic [AW-1:0]    x_a, w_a, half_a;
    logic             t_le_x, xpt_in, skip_col, den_zero;
    logic [22:0]      muq_m;
    logic [46:0]      muq_prod;
    logic [MUQ_W-1:0] muq_n;
    logic [24:0]      mz_prod;
    logic [MUQ_W-1:0] mz_n;
    logic [17:0]      ninv;
    logic [MUQ_W-1:0] pinv;
    logic [DEN_W-1:0] s_prod;
    logic [DIV_W-1:0] s_num, s_den, a_num, a_den;
    logic [DIV_W-1:0] ra_sum, ra_n;
    logic             wrap;
    logic [9:0]       qa_sum, zt_sum;
    logic [ZT_W-1:0]  qa_n, r_off, zt_n;
    logic             mem_lt_zt, lk_end, lk_cont, fl_same;

    assign load_idx = r_row_ready ? '0 : r_load_cnt;
    assign load_ok  = load_idx < MAXW;
    assign read_ok  = r_row_ready && (r_read_cnt < r_load_cnt);
    assign x_end    = (r_x == r_load_cnt);
    assign x_zero   = (r_x == '0);

    assign x_a      = AW'(r_x);
    assign w_a      = AW'(r_load_cnt);
    assign half_a   = AW'(r_half);
    assign t_le_x   = r_t <= x_a;
    assign xpt_in   = (x_a + r_t) < w_a;
    assign skip_col = (half_a > x_a) || ((x_a + half_a) >= w_a);
    assign den_zero = (r_den == '0);

    // mu_q = round(mu * 65536 / 1000) = floor((mu * 8192 + 62) / 125); the division
    // by 125 is a multiplication by ceil(2^30 / 125) followed by a 30-bit shift.
    assign muq_m    = {r_mu, 13'd0} + 23'd62;
    assign muq_prod = {24'd0, muq_m} * {23'd0, 24'd8589935};
    assign muq_n    = muq_prod[46:30];

    // mz = round(mu_q * Z / 65536) where Z = depth * 256.
    assign mz_prod = {8'd0, r_mu_q} * {17'd0, dep_q};
    assign mz_n    = MUQ_W'((mz_prod + 25'd128) >> 8);

    assign ninv    = 18'd131072 - {1'b0, r_mz};
    assign pinv    = 17'd65536 - r_mz;
    assign s_prod  = DEN_W'(r_eye) * DEN_W'(pinv);
    assign s_num   = {s_prod, 1'b0} + DIV_W'(ninv);
    assign s_den   = DIV_W'({ninv, 1'b0});
    assign a_num   = {ninv, 10'd0};
    assign a_den   = {r_den, 1'b0};

    always_comb begin
        div_start = 1'b0;
        div_num   = s_num;
        div_den   = s_den;
        unique case (i_cmd)
            C_S_GO: div_start = 1'b1;
            C_CHK: begin
                div_start = !skip_col && !den_zero;
                div_num   = a_num;
                div_den   = a_den;
            end
            default: div_start = 1'b0;
        endcase
    end

    // Probe offset kept as a running quotient and remainder of
    // (A * t + den) / (2 * den), so each step is one add and compare.
    assign ra_sum = r_ra + r_rstep;
    assign wrap   = ra_sum >= a_den;
    assign ra_n   = wrap ? ra_sum - a_den : ra_sum;
    assign qa_sum = 10'(r_qa) + 10'(r_qstep) + 10'(wrap);
    assign qa_n   = (qa_sum > 10'(ZT_MAX)) ? ZT_MAX : ZT_W'(qa_sum);
    assign r_off  = den_zero ? ZT_MAX : qa_n;
    assign zt_sum = 10'(r_zo) + 10'(r_off);
    assign zt_n   = (zt_sum > 10'(ZT_MAX)) ? ZT_MAX : ZT_W'(zt_sum);

    assign mem_lt_zt = {1'b0, dep_q} < r_zt;
    assign lk_end    = (lnk_q == r_left) || (lnk_q == r_right);
    assign lk_cont   = !lk_end && (lnk_q < r_right);
    assign fl_same   = (lnk_q == CW'(r_x));

    // Memory port selection.
    always_comb begin
        dep_we    = 1'b0;
        dep_re    = 1'b0;
        dep_raddr = CW'(r_x);
        pix_we    = 1'b0;
        pix_waddr = CW'(load_idx);
        pix_wdata = i_texture_rgb;
        pix_re    = 1'b0;
        pix_raddr = CW'(r_read_cnt);
        lnk_we    = 1'b0;
        lnk_waddr = CW'(r_x);
        lnk_wdata = CW'(r_x);
        lnk_re    = 1'b0;
        lnk_raddr = r_left;
        unique case (i_cmd)
            C_LOAD: begin
                dep_we = load_ok;
                pix_we = load_ok;
            end
            C_READ: pix_re = read_ok;
            C_LINIT: lnk_we = !x_end;
            C_COL_RD: dep_re = 1'b1;
            C_PROBE: begin
                dep_re    = 1'b1;
                dep_raddr = t_le_x ? CW'(x_a - r_t) : CW'(x_a + r_t);
            end
            C_PR_L: begin
                dep_re    = 1'b1;
                dep_raddr = CW'(x_a + r_t);
            end
            C_LK_RD: lnk_re = 1'b1;
            C_LK_STEP: begin
                lnk_re    = lk_cont;
                lnk_raddr = lnk_q;
                lnk_we    = !lk_cont;
                lnk_waddr = r_left;
                lnk_wdata = r_right;
            end
            C_FILL: begin
                lnk_re    = !x_zero;
                lnk_raddr = CW'(r_x - NW'(1));
            end
            C_FL_L: begin
                pix_re    = !fl_same;
                pix_raddr = lnk_q;
            end
            C_FL_C: begin
                pix_we    = 1'b1;
                pix_waddr = CW'(r_x);
                pix_wdata = pix_q;
            end
            default: dep_re = 1'b0;
        endcase
    end

    srg_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_WIDTH)) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (dep_we),
        .i_waddr (CW'(load_idx)),
        .i_wdata (i_depth),
        .i_re    (dep_re),
        .i_raddr (dep_raddr),
        .o_rdata (dep_q)
    );

    // Holds the texture after loading and the final colours after the fill.
    srg_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_waddr),
        .i_wdata (pix_wdata),
        .i_re    (pix_re),
        .i_raddr (pix_raddr),
        .o_rdata (pix_q)
    );

    srg_ram #(.WIDTH(CW), .DEPTH(MAX_WIDTH)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lnk_we),
        .i_waddr (lnk_waddr),
        .i_wdata (lnk_wdata),
        .i_re    (lnk_re),
        .i_raddr (lnk_raddr),
        .o_rdata (lnk_q)
    );

    srg_div #(.W(DIV_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye       <= EYE_RESET;
            r_mu        <= MU_RESET;
            r_load_cnt  <= '0;
            r_read_cnt  <= '0;
            r_row_ready <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_EYE_SEP: r_eye <= i_cfg_data;
                    REG_MU:      r_mu  <= i_cfg_data;
                    default:     r_eye <= r_eye;
                endcase
            end
            if (i_cmd == C_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd)
                C_LOAD: begin
                    // The first load after a finished row starts a new row.
                    if (r_row_ready) begin
                        r_row_ready <= 1'b0;
                        r_read_cnt  <= '0;
                    end
                    r_load_cnt <= load_idx + NW'(load_ok);
                end
                C_OUT: r_read_cnt <= r_read_cnt + NW'(1);
                C_DONE: begin
                    r_row_ready <= 1'b1;
                    r_read_cnt  <= '0;
                end
                default: r_row_ready <= r_row_ready;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            C_OUT: begin
                r_pix_out  <= pix_q;
                r_col_out  <= COL_W'(r_read_cnt);
                r_last_out <= (r_read_cnt + NW'(1)) == r_load_cnt;
            end
            C_MUQ_SET: begin
                r_mu_q <= (muq_n > 17'd65536) ? 17'd65536 : muq_n;
                r_x    <= '0;
            end
            C_DEN: r_den <= DEN_W'(r_mu_q) * DEN_W'(r_eye);
            C_LINIT: r_x <= x_end ? '0 : r_x + NW'(1);
            C_COL_Z: begin
                r_zo <= dep_q;
                r_mz <= mz_n;
            end
            C_S_SET: r_half <= REG_W'(div_quo[DIV_W-1:1]);
            C_CHK: begin
                r_left  <= CW'(x_a - half_a);
                r_right <= CW'(x_a + half_a);
                r_t     <= AW'(1);
                r_qa    <= '0;
                r_ra    <= DIV_W'(r_den);
            end
            C_A_SET: begin
                r_qstep <= (div_quo > DIV_W'(ZT_MAX)) ? ZT_MAX : ZT_W'(div_quo);
                r_rstep <= div_rem;
            end
            C_PROBE: begin
                r_ra  <= ra_n;
                r_qa  <= qa_n;
                r_zt  <= zt_n;
                r_vis <= 1'b1;
            end
            C_PR_L, C_PR_R: r_vis <= mem_lt_zt;
            C_PR_END: r_t <= r_t + AW'(1);
            C_LK_STEP: begin
                if (lk_cont) r_left <= lnk_q;
            end
            C_NEXT: r_x <= r_x + NW'(1);
            C_FILL: begin
                if (!x_zero) r_x <= r_x - NW'(1);
            end
            default: r_vis <= r_vis;
        endcase
    end

    always_comb begin
        o_stat.div_done  = div_done;
        o_stat.read_ok   = read_ok;
        o_stat.out_free  = !r_out_valid || i_out_ready;
        o_stat.x_end     = x_end;
        o_stat.skip_col  = skip_col;
        o_stat.den_zero  = den_zero;
        o_stat.t_le_x    = t_le_x;
        o_stat.xpt_in    = xpt_in;
        o_stat.mem_lt_zt = mem_lt_zt;
        o_stat.vis       = r_vis;
        o_stat.zt_sat    = (r_zt == ZT_MAX);
        o_stat.lk_cont   = lk_cont;
        o_stat.x_zero    = x_zero;
        o_stat.fl_same   = fl_same;
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_rgb  = r_pix_out;
    assign o_column     = r_col_out;
    assign o_last_pixel = r_last_out;

endmodule

// ----- rtl/sirds_row_generator.sv -----
// Top level of the stereogram row generator: controller plus datapath.
// Depends on srg_pkg, srg_if, srg_ctrl and srg_dp.
//
// Usage: send load items (op 0) carrying each column's depth and texture
// colour, left to right; the load marked last_column starts the row build.
// Then send read items (op 1); each returns one pixel on the output
// channel, left to right, with its column and a last_pixel flag. A read
// before the build has finished or after the last pixel returns nothing.
// eye_sep_px and mu_milli are written through the plain write port; the user
// must write them only while the block is idle; the block does not enforce it.
// Sequence: a read fetches its pixel into the pixel memory's read register,
// then, once the output register is free, into the output register. The
// build sets up mu_q and the denominator, does the link setup for each column,
// then per column runs the separation division and, for a column that is not
// skipped, the probe step division (unless the denominator is zero), the
// probe steps and the link steps, and at last the right-to-left colour fill.
// Input ready is high only while idle.
// Reset clears the row, counters and registers (eye 248, mu 333). When the
// receiver stalls, the pixel waits in the output register; loads are still
// taken, further reads wait until the register is free.
module sirds_row_generator #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  srg_pkg::t_reg_idx         i_cfg_idx,
    input  logic [srg_pkg::REG_W-1:0] i_cfg_data,
    srg_in_if.sink                    i_item,
    srg_out_if.source                 o_pixel
);
    import srg_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    srg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .i_op    (i_item.op),
        .i_last  (i_item.last_column),
        .i_stat  (stat),
        .o_ready (i_item.ready),
        .o_cmd   (cmd)
    );

    srg_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_depth       (i_item.depth),
        .i_texture_rgb (i_item.texture_rgb),
        .i_out_ready   (o_pixel.ready),
        .o_out_valid   (o_pixel.valid),
        .o_pixel_rgb   (o_pixel.pixel_rgb),
        .o_column      (o_pixel.column),
        .o_last_pixel  (o_pixel.last_pixel)
    );

endmodule
